>>> design/wavp_pkg.sv
package wavp_pkg;

  // Chunk tags as they appear big-endian in the shifted header word
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  // File layout and format defaults
  localparam logic [5:0]  HEADER_BYTES  = 6'd44;
  localparam logic [5:0]  RIFF_END_POS  = 6'd11;
  localparam logic [31:0] DEFAULT_RATE  = 32'd22050;
  localparam logic [15:0] PCM_BITS      = 16'd16;
  localparam logic [15:0] STEREO_CHANS  = 16'd2;
  localparam logic [31:0] FMT_MIN_SIZE  = 32'd16;

  // Record kinds
  localparam logic REC_SAMPLE = 1'b0;
  localparam logic REC_STATUS = 1'b1;

  // End-of-file status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOT_WAV = 2'd1;
  localparam logic [1:0] ST_NO_DATA = 2'd2;
  localparam logic [1:0] ST_NOT_16  = 2'd3;

  // Result queue geometry
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = 2;
  localparam int unsigned Q_CW    = 3;

  typedef struct packed {
    logic               record_kind;
    logic signed [16:0] sample_value;
    logic [1:0]         parse_status;
    logic [31:0]        rate_hz;
    logic               end_flag;
  } rec_t;

  // Records produced by one byte: zero, one or two, in order
  typedef struct packed {
    logic [1:0] count;
    rec_t       first;
    rec_t       second;
  } push_t;

  // Expected byte of the RIFF tag at file offset 0..3
  function automatic logic [7:0] riff_byte(input logic [1:0] pos);
    logic [7:0] val;
    case (pos)
      2'd0:    val = 8'h52;
      2'd1:    val = 8'h49;
      default: val = 8'h46;
    endcase
    return val;
  endfunction

endpackage

>>> design/wavp_if.sv
interface wavp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;

  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

interface wavp_out_if;
  logic               valid;
  logic               ready;
  logic               record_kind;
  logic signed [16:0] sample_value;
  logic [1:0]         parse_status;
  logic [31:0]        rate_hz;
  logic               end_flag;

  modport source (output valid, output record_kind, output sample_value,
                  output parse_status, output rate_hz, output end_flag, input ready);
  modport sink   (input valid, input record_kind, input sample_value,
                  input parse_status, input rate_hz, input end_flag, output ready);
endinterface

>>> design/wavp_parse.sv
module wavp_parse (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            take,
  input  logic [7:0]      data_byte,
  input  logic            is_last,
  output wavp_pkg::push_t push
);

  typedef enum logic [2:0] {
    PH_HEADER, PH_CHUNK, PH_FMT, PH_SKIP, PH_DATA
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [5:0]  hc_r, hc_nxt;
  logic [63:0] hdr_r, hdr_nxt;
  logic [32:0] skip_r, skip_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic [15:0] chan_r, chan_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic [31:0] drem_r, drem_nxt;
  logic [7:0]  low_r, low_nxt;
  logic [15:0] left_r, left_nxt;
  logic        badtag_r, badtag_nxt;
  logic        found_r, found_nxt;
  logic        lowh_r, lowh_nxt;
  logic        lefth_r, lefth_nxt;

  logic [63:0]        hdr_shift;
  logic [31:0]        chunk_size;
  logic [31:0]        chunk_tag;
  logic [32:0]        skip_len;
  logic [32:0]        skip_dec;
  logic [4:0]         idx_inc;
  logic [2:0]         fmt_sel;
  logic [15:0]        raw;
  logic               emit_ok;
  logic               samp_vld;
  logic signed [16:0] samp_val;
  logic [1:0]         status;
  wavp_pkg::rec_t     samp_rec;
  wavp_pkg::rec_t     stat_rec;

  // Byte-wise parse step
  always_comb begin
    phase_nxt  = phase_r;
    hdr_nxt    = hdr_r;
    skip_nxt   = skip_r;
    idx_nxt    = idx_r;
    chan_nxt   = chan_r;
    rate_nxt   = rate_r;
    bits_nxt   = bits_r;
    drem_nxt   = drem_r;
    low_nxt    = low_r;
    left_nxt   = left_r;
    badtag_nxt = badtag_r;
    found_nxt  = found_r;
    lowh_nxt   = lowh_r;
    lefth_nxt  = lefth_r;
    samp_vld   = 1'b0;
    samp_val   = '0;

    hc_nxt     = (hc_r < wavp_pkg::HEADER_BYTES) ? hc_r + 6'd1 : hc_r;
    hdr_shift  = {hdr_r[55:0], data_byte};
    chunk_tag  = hdr_shift[63:32];
    chunk_size = {hdr_shift[7:0], hdr_shift[15:8], hdr_shift[23:16], hdr_shift[31:24]};
    skip_len   = {1'b0, chunk_size} + {32'd0, chunk_size[0]};
    skip_dec   = (skip_r != 33'd0) ? skip_r - 33'd1 : skip_r;
    idx_inc    = idx_r + 5'd1;
    fmt_sel    = idx_r[2:0] - 3'd2;
    raw        = {data_byte, low_r};
    emit_ok    = !badtag_r && (bits_r == wavp_pkg::PCM_BITS);

    case (phase_r)
      PH_HEADER: begin
        // Check the RIFF tag, ignore the size and form type
        if (hc_r < 6'd4 && data_byte != wavp_pkg::riff_byte(hc_r[1:0])) badtag_nxt = 1'b1;
        if (hc_r >= wavp_pkg::RIFF_END_POS) begin
          phase_nxt = PH_CHUNK;
          idx_nxt   = '0;
          hdr_nxt   = '0;
        end
      end
      PH_CHUNK: begin
        // Collect the 8-byte chunk header, then dispatch on its tag
        hdr_nxt = hdr_shift;
        idx_nxt = idx_inc;
        if (idx_inc >= 5'd8) begin
          idx_nxt = '0;
          hdr_nxt = '0;
          if (chunk_tag == wavp_pkg::TAG_DATA) begin
            found_nxt = 1'b1;
            lowh_nxt  = 1'b0;
            lefth_nxt = 1'b0;
            drem_nxt  = chunk_size;
            phase_nxt = PH_DATA;
          end else begin
            skip_nxt = skip_len;
            if (chunk_tag == wavp_pkg::TAG_FMT && chunk_size >= wavp_pkg::FMT_MIN_SIZE) begin
              phase_nxt = PH_FMT;
            end else begin
              phase_nxt = (skip_len == 33'd0) ? PH_CHUNK : PH_SKIP;
            end
          end
        end
      end
      PH_FMT: begin
        // Gather channels and rate, then bits; commit on the sixteenth byte
        skip_nxt = skip_r - 33'd1;
        if (idx_r inside {[5'd2:5'd7]}) begin
          hdr_nxt[{fmt_sel, 3'b000} +: 8] = data_byte;
        end else if (idx_r == 5'd14) begin
          low_nxt = data_byte;
        end
        idx_nxt = idx_inc;
        if (idx_inc >= 5'd16) begin
          chan_nxt  = hdr_r[15:0];
          rate_nxt  = hdr_r[47:16];
          bits_nxt  = {data_byte, low_r};
          hdr_nxt   = '0;
          low_nxt   = '0;
          idx_nxt   = '0;
          phase_nxt = (skip_nxt == 33'd0) ? PH_CHUNK : PH_SKIP;
        end
      end
      PH_SKIP: begin
        // Drop body bytes of uninteresting chunks
        skip_nxt = skip_dec;
        if (skip_dec == 33'd0) begin
          phase_nxt = PH_CHUNK;
          idx_nxt   = '0;
          hdr_nxt   = '0;
        end
      end
      PH_DATA: begin
        // Pair bytes into samples, and samples into stereo sums
        if (drem_r != 32'd0) begin
          drem_nxt = drem_r - 32'd1;
          if (!lowh_r) begin
            low_nxt  = data_byte;
            lowh_nxt = 1'b1;
          end else begin
            lowh_nxt = 1'b0;
            if (chan_r == wavp_pkg::STEREO_CHANS) begin
              if (lefth_r) begin
                lefth_nxt = 1'b0;
                samp_vld  = emit_ok;
                samp_val  = $signed({left_r[15], left_r}) + $signed({raw[15], raw});
              end else begin
                left_nxt  = raw;
                lefth_nxt = 1'b1;
              end
            end else begin
              samp_vld = emit_ok;
              samp_val = $signed({raw, 1'b0});
            end
          end
        end
      end
      default: begin
        phase_nxt = PH_SKIP;
        skip_nxt  = '0;
      end
    endcase

    // Final status from the state after this byte
    if (badtag_nxt || hc_nxt < wavp_pkg::HEADER_BYTES) begin
      status = wavp_pkg::ST_NOT_WAV;
    end else if (!found_nxt) begin
      status = wavp_pkg::ST_NO_DATA;
    end else if (bits_nxt != wavp_pkg::PCM_BITS) begin
      status = wavp_pkg::ST_NOT_16;
    end else begin
      status = wavp_pkg::ST_OK;
    end

    samp_rec.record_kind  = wavp_pkg::REC_SAMPLE;
    samp_rec.sample_value = samp_val;
    samp_rec.parse_status = wavp_pkg::ST_OK;
    samp_rec.rate_hz      = '0;
    samp_rec.end_flag     = 1'b0;

    stat_rec.record_kind  = wavp_pkg::REC_STATUS;
    stat_rec.sample_value = '0;
    stat_rec.parse_status = status;
    stat_rec.rate_hz      = rate_nxt;
    stat_rec.end_flag     = 1'b1;

    // Start a new file after the last byte
    if (is_last) begin
      hc_nxt     = '0;
      phase_nxt  = PH_HEADER;
      hdr_nxt    = '0;
      skip_nxt   = '0;
      idx_nxt    = '0;
      chan_nxt   = 16'd1;
      rate_nxt   = wavp_pkg::DEFAULT_RATE;
      bits_nxt   = wavp_pkg::PCM_BITS;
      drem_nxt   = '0;
      low_nxt    = '0;
      left_nxt   = '0;
      badtag_nxt = 1'b0;
      found_nxt  = 1'b0;
      lowh_nxt   = 1'b0;
      lefth_nxt  = 1'b0;
    end
  end

  // Hand the records of this byte to the queue, sample first
  always_comb begin
    push.count  = take ? ({1'b0, samp_vld} + {1'b0, is_last}) : 2'd0;
    push.first  = samp_vld ? samp_rec : stat_rec;
    push.second = stat_rec;
  end

  // Advance the parse state on each taken byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc_r     <= '0;
      phase_r  <= PH_HEADER;
      hdr_r    <= '0;
      skip_r   <= '0;
      idx_r    <= '0;
      chan_r   <= 16'd1;
      rate_r   <= wavp_pkg::DEFAULT_RATE;
      bits_r   <= wavp_pkg::PCM_BITS;
      drem_r   <= '0;
      low_r    <= '0;
      left_r   <= '0;
      badtag_r <= 1'b0;
      found_r  <= 1'b0;
      lowh_r   <= 1'b0;
      lefth_r  <= 1'b0;
    end else if (take) begin
      hc_r     <= hc_nxt;
      phase_r  <= phase_nxt;
      hdr_r    <= hdr_nxt;
      skip_r   <= skip_nxt;
      idx_r    <= idx_nxt;
      chan_r   <= chan_nxt;
      rate_r   <= rate_nxt;
      bits_r   <= bits_nxt;
      drem_r   <= drem_nxt;
      low_r    <= low_nxt;
      left_r   <= left_nxt;
      badtag_r <= badtag_nxt;
      found_r  <= found_nxt;
      lowh_r   <= lowh_nxt;
      lefth_r  <= lefth_nxt;
    end
  end

  // A taken last byte leaves the parser at the start of a new file
  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    take && is_last |=> phase_r == PH_HEADER && hc_r == 6'd0 && !found_r)
    else $error("parser did not restart after the last byte");

  // Sample records only come out of the data chunk, and never after a bad tag
  a_sample_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    push.count != 2'd0 && push.first.record_kind == wavp_pkg::REC_SAMPLE
      |-> phase_r == PH_DATA && !badtag_r)
    else $error("sample record outside the data chunk");

endmodule

>>> design/wavp_fifo.sv
module wavp_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  wavp_pkg::push_t push,
  output logic            room,
  output logic            out_valid,
  input  logic            out_ready,
  output wavp_pkg::rec_t  out_rec
);

  wavp_pkg::rec_t                mem_r [wavp_pkg::Q_DEPTH];
  logic [wavp_pkg::Q_AW-1:0]     wp_r, wp_nxt;
  logic [wavp_pkg::Q_AW-1:0]     rp_r, rp_nxt;
  logic [wavp_pkg::Q_CW-1:0]     cnt_r, cnt_nxt;
  logic                          pop;

  // Room for the worst case of two records from one byte
  assign room      = cnt_r <= wavp_pkg::Q_CW'(wavp_pkg::Q_DEPTH - 2);
  assign out_valid = cnt_r != '0;
  assign out_rec   = mem_r[rp_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    wp_nxt  = wp_r + wavp_pkg::Q_AW'(push.count);
    rp_nxt  = rp_r + wavp_pkg::Q_AW'(pop);
    cnt_nxt = cnt_r + wavp_pkg::Q_CW'(push.count) - wavp_pkg::Q_CW'(pop);
  end

  // Store pushed records
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem_r[wp_r] <= push.first;
    if (push.count == 2'd2) mem_r[wp_r + wavp_pkg::Q_AW'(1)] <= push.second;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.count != 2'd0 |-> room)
    else $error("record pushed into a full queue");

  a_fill_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    push.count == 2'd2 && !pop |=> cnt_r == $past(cnt_r) + wavp_pkg::Q_CW'(2))
    else $error("queue fill count lost a record");

endmodule

>>> design/wav_pcm16_stream_parser_unit.sv
// WAV PCM16 stream parser.
// in_if carries one byte of a WAV file per transfer, in file order, with
// is_last high on the final byte. out_if carries records: sample records
// (record_kind 0) with a Q1.16 mono sample, and one status record
// (record_kind 1, end_flag 1) after the last byte with the parse status and
// the sample rate. Samples sent before a nonzero status are to be discarded.
// Throughput: one byte per clock while the queue has room. Each byte waits in
// the input register, is parsed when taken, and its records enter the result
// queue. The last byte can yield two records; the four-entry queue absorbs
// them, and input stalls only when fewer than two entries are free. A receiver
// stall fills the queue and then holds off input; nothing is lost.
// Reset (rst_n low, synchronous) empties the queue and input register and
// returns the parser to the start of a file. The parser also returns there by
// itself after each last byte, so files can follow back to back.
module wav_pcm16_stream_parser_unit (
  input  logic clk,
  input  logic rst_n,
  wavp_in_if.sink    in_if,
  wavp_out_if.source out_if
);

  logic            in_valid_r;
  logic [7:0]      in_byte_r;
  logic            in_last_r;
  logic            room;
  logic            take;
  wavp_pkg::push_t push;
  wavp_pkg::rec_t  out_rec;

  assign take        = in_valid_r && room;
  assign in_if.ready = !in_valid_r || room;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      in_byte_r <= in_if.data_byte;
      in_last_r <= in_if.is_last;
    end
  end

  wavp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .data_byte (in_byte_r),
    .is_last   (in_last_r),
    .push      (push)
  );

  wavp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_rec   (out_rec)
  );

  assign out_if.record_kind  = out_rec.record_kind;
  assign out_if.sample_value = out_rec.sample_value;
  assign out_if.parse_status = out_rec.parse_status;
  assign out_if.rate_hz      = out_rec.rate_hz;
  assign out_if.end_flag     = out_rec.end_flag;

endmodule
